[hdl/polyphase_dft_analysis_bank_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the polyphase DFT analysis bank.
// Implication checks, both sampled on the rising clock edge and disabled
// while reset is applied.
// ---------------------------------------------------------------------------
`ifndef POLYPHASE_DFT_ANALYSIS_BANK_ASSERT_SVH
`define POLYPHASE_DFT_ANALYSIS_BANK_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PDAB_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdab assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PDAB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdab assertion failed");

`endif

[hdl/pdab_pkg.sv]
// ---------------------------------------------------------------------------
// pdab_pkg
// Constants, types and arithmetic helpers shared by the analysis bank.
// ---------------------------------------------------------------------------
package pdab_pkg;

    localparam int CHANNELS        = 64;
    localparam int TAPS_PER_BRANCH = 4;
    localparam int SAMPLE_BITS     = 16;
    localparam int NTAPS           = CHANNELS * TAPS_PER_BRANCH;

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TAP_W  = (TAPS_PER_BRANCH > 1) ? $clog2(TAPS_PER_BRANCH) : 1;
    localparam int ADDR_W = $clog2(NTAPS);
    localparam int COEF_W = 18;
    localparam int SUM_W  = 24;
    localparam int TW_W   = 16;
    localparam int BIN_W  = 32;
    localparam int PROD_W = SUM_W + TW_W;
    localparam int ACC_W  = PROD_W + CH_W + 1;

    localparam longint unsigned Q30_TWO_PI  = 64'd6746518852;
    localparam longint unsigned Q30_PI      = 64'd3373259426;
    localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
    localparam longint unsigned TW_DEN      = 4 * CHANNELS;
    localparam longint unsigned TW_HALF_DEN = TW_DEN / 2;

    // Divisors (2n-1)*(2n) of the Taylor terms, n = 1..10.
    localparam longint unsigned TAYLOR_DIV [10] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
        64'd132, 64'd182, 64'd240, 64'd306, 64'd380
    };

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_PUSH    = 2'd1,
        CMD_RESTART = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BRANCH,
        ST_BDRAIN,
        ST_DFT,
        ST_DDRAIN
    } state_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] coef_addr;
        logic [ADDR_W-1:0] hist_addr;
    } rd_req_t;

    typedef struct packed {
        logic            vld;
        logic            dft;
        logic            first;
        logic            last;
        logic [CH_W-1:0] idx;
        logic [CH_W-1:0] p;
        logic [CH_W-1:0] tw;
    } issue_t;

    typedef logic signed [TW_W-1:0] rom_t [CHANNELS];

    // Q1.15 cosine of 2*pi*j/TW_DEN from an eleven-term Taylor series in Q.30.
    function automatic logic signed [TW_W-1:0] twiddle_q15(input longint unsigned j);
        longint unsigned th;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        longint          q;
        logic            neg;
        neg = 1'b0;
        th  = (j * Q30_TWO_PI + TW_HALF_DEN) / TW_DEN;
        if (th > Q30_TWO_PI) th = Q30_TWO_PI;
        if (th > Q30_PI) th = Q30_TWO_PI - th;
        if (th > Q30_HALF_PI)
        begin
            th  = Q30_PI - th;
            neg = 1'b1;
        end
        x2   = (th * th) >> 30;
        term = 64'd1 << 30;
        acc  = longint'(term);
        for (int n = 1; n <= 10; n++)
        begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n - 1];
            if ((n & 1) == 1) acc = acc - longint'(term);
            else acc = acc + longint'(term);
        end
        q = (acc + 64'sd16384) >>> 15;
        if (q > 32767) q = 32767;
        if (q < -32767) q = -32767;
        return neg ? TW_W'(-q) : TW_W'(q);
    endfunction

    function automatic rom_t build_cos();
        rom_t r;
        for (int i = 0; i < CHANNELS; i++)
        begin
            r[i] = twiddle_q15(longint'(4 * i));
        end
        return r;
    endfunction

    function automatic rom_t build_sin();
        rom_t r;
        int   j;
        for (int i = 0; i < CHANNELS; i++)
        begin
            j = 4 * i + 3 * CHANNELS;
            if (j >= 4 * CHANNELS) j = j - 4 * CHANNELS;
            r[i] = twiddle_q15(longint'(j));
        end
        return r;
    endfunction

    // Round half up, right by 15 bits (floor of (v + 2^14) / 2^15).
    function automatic logic signed [ACC_W-1:0] rnd15(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = v + ACC_W'(16384);
        return t >>> 15;
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'((64'sd1 <<< (SUM_W - 1)) - 64'sd1);
        lo = -hi - ACC_W'(1);
        if (v > hi) return hi[SUM_W-1:0];
        if (v < lo) return lo[SUM_W-1:0];
        return v[SUM_W-1:0];
    endfunction

    function automatic logic signed [BIN_W-1:0] sat_bin(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'((64'sd1 <<< (BIN_W - 1)) - 64'sd1);
        lo = -hi - ACC_W'(1);
        if (v > hi) return hi[BIN_W-1:0];
        if (v < lo) return lo[BIN_W-1:0];
        return v[BIN_W-1:0];
    endfunction

endpackage

[hdl/pdab_tap_store.sv]
// ---------------------------------------------------------------------------
// pdab_tap_store
// Sample history and prototype coefficient memories with registered reads.
// ---------------------------------------------------------------------------
module pdab_tap_store (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                coef_we,
    input  logic [pdab_pkg::ADDR_W-1:0]         coef_waddr,
    input  logic signed [pdab_pkg::COEF_W-1:0]  coef_wdata,
    input  logic                                hist_we,
    input  logic [pdab_pkg::ADDR_W-1:0]         hist_waddr,
    input  logic signed [pdab_pkg::SAMPLE_BITS-1:0] hist_wdata,
    input  logic                                hist_clear,
    input  pdab_pkg::rd_req_t                   rd,
    output logic signed [pdab_pkg::COEF_W-1:0]  coef_q,
    output logic signed [pdab_pkg::SAMPLE_BITS-1:0] hist_q
);

    logic signed [pdab_pkg::COEF_W-1:0]      coef_mem [pdab_pkg::NTAPS];
    logic signed [pdab_pkg::SAMPLE_BITS-1:0] hist_mem [pdab_pkg::NTAPS];
    logic [pdab_pkg::NTAPS-1:0]              hist_vld_reg;
    logic signed [pdab_pkg::COEF_W-1:0]      coef_rd_reg;
    logic signed [pdab_pkg::SAMPLE_BITS-1:0] hist_rd_reg;
    logic                                    hist_rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[coef_waddr] <= coef_wdata;
        end
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        if (rd.en)
        begin
            coef_rd_reg <= coef_mem[rd.coef_addr];
            hist_rd_reg <= hist_mem[rd.hist_addr];
        end
    end

    // An entry not written since reset or restart reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_vld_reg    <= '0;
            hist_rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (hist_clear)
            begin
                hist_vld_reg <= '0;
            end
            else if (hist_we)
            begin
                hist_vld_reg[hist_waddr] <= 1'b1;
            end
            if (rd.en)
            begin
                hist_rd_vld_reg <= hist_vld_reg[rd.hist_addr];
            end
        end
    end

    assign coef_q = coef_rd_reg;
    assign hist_q = hist_rd_vld_reg ? hist_rd_reg : '0;

endmodule

[hdl/pdab_mac_pipe.sv]
// ---------------------------------------------------------------------------
// pdab_mac_pipe
// Shared multiply-accumulate pipeline, branch sum memory, cosine and sine twiddle
// ROMs and the result register.
// ---------------------------------------------------------------------------
`include "polyphase_dft_analysis_bank_assert.svh"

module pdab_mac_pipe (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  pdab_pkg::issue_t                        issue,
    input  logic signed [pdab_pkg::COEF_W-1:0]      coef_q,
    input  logic signed [pdab_pkg::SAMPLE_BITS-1:0] hist_q,
    output logic                                    busy,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [pdab_pkg::CH_W-1:0]               out_channel,
    output logic signed [pdab_pkg::BIN_W-1:0]       out_real,
    output logic signed [pdab_pkg::BIN_W-1:0]       out_imag,
    output logic                                    out_last
);

    localparam pdab_pkg::rom_t COS_ROM = pdab_pkg::build_cos();
    localparam pdab_pkg::rom_t SIN_ROM = pdab_pkg::build_sin();

    logic signed [pdab_pkg::SUM_W-1:0]  sum_mem [pdab_pkg::CHANNELS];
    logic signed [pdab_pkg::SUM_W-1:0]  sum_rd_reg;
    logic signed [pdab_pkg::TW_W-1:0]   cos_reg;
    logic signed [pdab_pkg::TW_W-1:0]   sin_reg;

    pdab_pkg::issue_t                   s1_reg;
    pdab_pkg::issue_t                   s2_reg;
    logic signed [pdab_pkg::PROD_W-1:0] prod_re_reg;
    logic signed [pdab_pkg::PROD_W-1:0] prod_im_reg;
    logic signed [pdab_pkg::ACC_W-1:0]  acc_re_reg;
    logic signed [pdab_pkg::ACC_W-1:0]  acc_im_reg;
    logic signed [pdab_pkg::ACC_W-1:0]  acc_re_next;
    logic signed [pdab_pkg::ACC_W-1:0]  acc_im_next;
    logic                               fin_reg;
    logic                               fin_dft_reg;
    logic [pdab_pkg::CH_W-1:0]          fin_idx_reg;

    logic signed [pdab_pkg::SUM_W-1:0]  op_a;
    logic signed [pdab_pkg::TW_W-1:0]   op_b;
    logic signed [pdab_pkg::SUM_W-1:0]  coef_ext;
    logic signed [pdab_pkg::TW_W-1:0]   hist_ext;

    logic                               out_valid_reg;
    logic [pdab_pkg::CH_W-1:0]          out_channel_reg;
    logic signed [pdab_pkg::BIN_W-1:0]  out_real_reg;
    logic signed [pdab_pkg::BIN_W-1:0]  out_imag_reg;
    logic                               out_last_reg;

    // Stage 0: branch sum and twiddle reads.
    always_ff @(posedge clk)
    begin
        if (issue.vld && issue.dft)
        begin
            sum_rd_reg <= sum_mem[issue.p];
            cos_reg    <= COS_ROM[issue.tw];
            sin_reg    <= SIN_ROM[issue.tw];
        end
        if (fin_reg && !fin_dft_reg)
        begin
            sum_mem[fin_idx_reg] <= pdab_pkg::sat_sum(pdab_pkg::rnd15(acc_re_reg));
        end
    end

    // Stage 1 operands: the branch phase uses tap memory data.
    assign coef_ext = pdab_pkg::SUM_W'(coef_q);
    assign hist_ext = pdab_pkg::TW_W'(hist_q);
    assign op_a     = s1_reg.dft ? sum_rd_reg : coef_ext;
    assign op_b     = s1_reg.dft ? cos_reg : hist_ext;

    always_ff @(posedge clk)
    begin
        if (s1_reg.vld)
        begin
            prod_re_reg <= op_a * op_b;
            prod_im_reg <= sum_rd_reg * sin_reg;
        end
        if (s2_reg.vld)
        begin
            acc_re_reg <= acc_re_next;
            acc_im_reg <= acc_im_next;
        end
    end

    always_comb
    begin
        if (s2_reg.first)
        begin
            acc_re_next = pdab_pkg::ACC_W'(prod_re_reg);
            acc_im_next = -pdab_pkg::ACC_W'(prod_im_reg);
        end
        else
        begin
            acc_re_next = acc_re_reg + pdab_pkg::ACC_W'(prod_re_reg);
            acc_im_next = acc_im_reg - pdab_pkg::ACC_W'(prod_im_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg        <= '0;
            s2_reg        <= '0;
            fin_reg       <= 1'b0;
            fin_dft_reg   <= 1'b0;
            fin_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_reg      <= issue;
            s2_reg      <= s1_reg;
            fin_reg     <= s2_reg.vld && s2_reg.last;
            fin_dft_reg <= s2_reg.dft;
            fin_idx_reg <= s2_reg.idx;
            if (fin_reg && fin_dft_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_reg && fin_dft_reg)
        begin
            out_channel_reg <= fin_idx_reg;
            out_real_reg    <= pdab_pkg::sat_bin(pdab_pkg::rnd15(acc_re_reg));
            out_imag_reg    <= pdab_pkg::sat_bin(pdab_pkg::rnd15(acc_im_reg));
            out_last_reg    <= (int'(fin_idx_reg) == pdab_pkg::CHANNELS - 1);
        end
    end

    assign busy        = s1_reg.vld || s2_reg.vld || fin_reg;
    assign out_valid   = out_valid_reg;
    assign out_channel = out_channel_reg;
    assign out_real    = out_real_reg;
    assign out_imag    = out_imag_reg;
    assign out_last    = out_last_reg;

    // A finished bin never lands on a result that is still waiting.
    `PDAB_ASSERT_SAME(a_no_overwrite, fin_reg && fin_dft_reg, !out_valid_reg)
    // No term enters the pipeline while a result waits to be taken.
    `PDAB_ASSERT_SAME(a_hold_while_out, out_valid_reg, !issue.vld && !s1_reg.vld)
    // The DFT phase only starts on a drained pipeline.
    `PDAB_ASSERT_SAME(a_phase_order, s1_reg.vld && s2_reg.vld, s1_reg.dft == s2_reg.dft)

endmodule

[hdl/polyphase_dft_analysis_bank.sv]
// ---------------------------------------------------------------------------
// polyphase_dft_analysis_bank
// Uniform polyphase DFT analysis filterbank for real samples.
// ---------------------------------------------------------------------------
// Loads, restarts and pushes that do not complete a block are taken while
// the block is idle. A push that completes a block of CHANNELS samples starts
// a run on one shared multiply-accumulate pipeline that takes one term per
// cycle: first CHANNELS*TAPS_PER_BRANCH branch terms read from the sample
// history and coefficient memories, then a drain of the pipeline, then for
// each channel k CHANNELS DFT terms from the branch sums and twiddle ROMs, a
// drain and the handoff of the result word. A result word that waits for the
// receiver holds the run until it is taken. The input is not ready while a
// block is being worked on. Each of the CHANNELS result words carries its
// channel number, and the word for the highest channel has last set. Restart
// clears the history at once through per-entry valid bits, so no clearing
// pass follows reset. Coefficients are not cleared; every tap must be loaded
// before the first block completes.
// ---------------------------------------------------------------------------
module polyphase_dft_analysis_bank (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [1:0]                              cmd,
    input  logic signed [15:0]                      sample,
    input  logic [7:0]                              coef_index,
    input  logic signed [pdab_pkg::COEF_W-1:0]      coef_value,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [pdab_pkg::CH_W-1:0]               channel,
    output logic signed [pdab_pkg::BIN_W-1:0]       bin_real,
    output logic signed [pdab_pkg::BIN_W-1:0]       bin_imag,
    output logic                                    last
);

    pdab_pkg::state_t            state_reg;
    pdab_pkg::state_t            state_next;
    logic [pdab_pkg::CH_W-1:0]   fill_reg;
    logic [pdab_pkg::CH_W-1:0]   fill_next;
    logic [pdab_pkg::TAP_W-1:0]  head_reg;
    logic [pdab_pkg::TAP_W-1:0]  head_next;
    logic [pdab_pkg::TAP_W-1:0]  r_reg;
    logic [pdab_pkg::TAP_W-1:0]  r_next;
    logic [pdab_pkg::TAP_W-1:0]  slot_reg;
    logic [pdab_pkg::TAP_W-1:0]  slot_next;
    logic [pdab_pkg::CH_W-1:0]   p_reg;
    logic [pdab_pkg::CH_W-1:0]   p_next;
    logic [pdab_pkg::CH_W-1:0]   k_reg;
    logic [pdab_pkg::CH_W-1:0]   k_next;
    logic [pdab_pkg::CH_W-1:0]   tw_reg;
    logic [pdab_pkg::CH_W-1:0]   tw_next;
    logic [pdab_pkg::CH_W:0]     tw_sum;

    logic                        accept;
    logic                        is_load;
    logic                        is_push;
    logic                        is_restart;
    logic                        block_done;
    logic                        branch_end;
    logic                        dft_end;
    logic                        pipe_busy;
    logic                        drained;
    logic                        last_k;

    logic                        coef_we;
    logic                        hist_we;
    logic [pdab_pkg::ADDR_W-1:0] hist_waddr;
    pdab_pkg::rd_req_t           rd;
    pdab_pkg::issue_t            issue;
    logic signed [pdab_pkg::COEF_W-1:0]      coef_q;
    logic signed [pdab_pkg::SAMPLE_BITS-1:0] hist_q;

    assign accept     = in_valid && in_ready;
    assign is_load    = (cmd == pdab_pkg::CMD_LOAD);
    assign is_push    = (cmd == pdab_pkg::CMD_PUSH);
    assign is_restart = (cmd == pdab_pkg::CMD_RESTART);
    assign block_done = accept && is_push && (int'(fill_reg) == pdab_pkg::CHANNELS - 1);
    assign branch_end = (int'(p_reg) == pdab_pkg::CHANNELS - 1)
                     && (int'(r_reg) == pdab_pkg::TAPS_PER_BRANCH - 1);
    assign dft_end    = (int'(p_reg) == pdab_pkg::CHANNELS - 1);
    assign drained    = !pipe_busy && !out_valid;
    assign last_k     = (int'(k_reg) == pdab_pkg::CHANNELS - 1);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pdab_pkg::ST_IDLE:   if (block_done) state_next = pdab_pkg::ST_BRANCH;
            pdab_pkg::ST_BRANCH: if (branch_end) state_next = pdab_pkg::ST_BDRAIN;
            pdab_pkg::ST_BDRAIN: if (!pipe_busy) state_next = pdab_pkg::ST_DFT;
            pdab_pkg::ST_DFT:    if (dft_end) state_next = pdab_pkg::ST_DDRAIN;
            pdab_pkg::ST_DDRAIN:
            begin
                if (drained)
                begin
                    state_next = last_k ? pdab_pkg::ST_IDLE : pdab_pkg::ST_DFT;
                end
            end
            default:             state_next = pdab_pkg::ST_IDLE;
        endcase
    end

    // Counters of the history write and of the term sequence.
    assign tw_sum = {1'b0, tw_reg} + {1'b0, k_reg};

    always_comb
    begin
        fill_next = fill_reg;
        head_next = head_reg;
        r_next    = r_reg;
        slot_next = slot_reg;
        p_next    = p_reg;
        k_next    = k_reg;
        tw_next   = tw_reg;
        unique case (state_reg)
            pdab_pkg::ST_IDLE:
            begin
                if (accept && is_restart)
                begin
                    fill_next = '0;
                    head_next = '0;
                end
                else if (accept && is_push)
                begin
                    fill_next = block_done ? '0 : fill_reg + 1'b1;
                end
                r_next    = '0;
                slot_next = head_reg;
                p_next    = '0;
                k_next    = '0;
                tw_next   = '0;
            end
            pdab_pkg::ST_BRANCH:
            begin
                if (int'(r_reg) == pdab_pkg::TAPS_PER_BRANCH - 1)
                begin
                    r_next    = '0;
                    slot_next = head_reg;
                    p_next    = p_reg + 1'b1;
                end
                else
                begin
                    r_next    = r_reg + 1'b1;
                    slot_next = (slot_reg == '0)
                              ? pdab_pkg::TAP_W'(pdab_pkg::TAPS_PER_BRANCH - 1)
                              : slot_reg - 1'b1;
                end
            end
            pdab_pkg::ST_BDRAIN:
            begin
                p_next  = '0;
                k_next  = '0;
                tw_next = '0;
            end
            pdab_pkg::ST_DFT:
            begin
                p_next  = p_reg + 1'b1;
                tw_next = (int'(tw_sum) >= pdab_pkg::CHANNELS)
                        ? pdab_pkg::CH_W'(int'(tw_sum) - pdab_pkg::CHANNELS)
                        : tw_sum[pdab_pkg::CH_W-1:0];
            end
            pdab_pkg::ST_DDRAIN:
            begin
                p_next  = '0;
                tw_next = '0;
                if (drained)
                begin
                    if (last_k)
                    begin
                        k_next    = '0;
                        head_next = (int'(head_reg) == pdab_pkg::TAPS_PER_BRANCH - 1)
                                  ? '0 : head_reg + 1'b1;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                p_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pdab_pkg::ST_IDLE;
            fill_reg  <= '0;
            head_reg  <= '0;
            r_reg     <= '0;
            slot_reg  <= '0;
            p_reg     <= '0;
            k_reg     <= '0;
            tw_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            head_reg  <= head_next;
            r_reg     <= r_next;
            slot_reg  <= slot_next;
            p_reg     <= p_next;
            k_reg     <= k_next;
            tw_reg    <= tw_next;
        end
    end

    // Outputs of the state machine: handshake, memory writes and term issue.
    always_comb
    begin
        in_ready     = 1'b0;
        coef_we      = 1'b0;
        hist_we      = 1'b0;
        rd           = '0;
        issue        = '0;
        rd.coef_addr = pdab_pkg::ADDR_W'(int'(r_reg) * pdab_pkg::CHANNELS + int'(p_reg));
        rd.hist_addr = pdab_pkg::ADDR_W'(int'(slot_reg) * pdab_pkg::CHANNELS + int'(p_reg));
        issue.p      = p_reg;
        issue.tw     = tw_reg;
        unique case (state_reg)
            pdab_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                coef_we  = in_valid && is_load
                        && (int'(coef_index) < pdab_pkg::NTAPS);
                hist_we  = in_valid && is_push;
            end
            pdab_pkg::ST_BRANCH:
            begin
                rd.en       = 1'b1;
                issue.vld   = 1'b1;
                issue.first = (r_reg == '0);
                issue.last  = (int'(r_reg) == pdab_pkg::TAPS_PER_BRANCH - 1);
                issue.idx   = p_reg;
            end
            pdab_pkg::ST_DFT:
            begin
                issue.vld   = 1'b1;
                issue.dft   = 1'b1;
                issue.first = (p_reg == '0);
                issue.last  = dft_end;
                issue.idx   = k_reg;
            end
            pdab_pkg::ST_BDRAIN, pdab_pkg::ST_DDRAIN:
            begin
                issue.vld = 1'b0;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign hist_waddr = pdab_pkg::ADDR_W'(int'(head_reg) * pdab_pkg::CHANNELS
                                          + int'(fill_reg));

    pdab_tap_store u_tap_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .coef_we    (coef_we),
        .coef_waddr (pdab_pkg::ADDR_W'(coef_index)),
        .coef_wdata (coef_value),
        .hist_we    (hist_we),
        .hist_waddr (hist_waddr),
        .hist_wdata (sample[pdab_pkg::SAMPLE_BITS-1:0]),
        .hist_clear (accept && is_restart),
        .rd         (rd),
        .coef_q     (coef_q),
        .hist_q     (hist_q)
    );

    pdab_mac_pipe u_mac_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue       (issue),
        .coef_q      (coef_q),
        .hist_q      (hist_q),
        .busy        (pipe_busy),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_channel (channel),
        .out_real    (bin_real),
        .out_imag    (bin_imag),
        .out_last    (last)
    );

endmodule

[tb/tb_polyphase_dft_analysis_bank.sv]
// ---------------------------------------------------------------------------
// Testbench for polyphase_dft_analysis_bank
// Every tap is loaded first. A short directed table then covers the extremes
// of the sample and tap fields, every command, a restart in the middle of a
// block and a full block of extreme samples. A short random run of mostly
// sample pushes follows and leaves a partial block held. Every result word is
// checked against an in-bench branch filter and DFT model or typed-in zeros.
// ---------------------------------------------------------------------------
module tb_polyphase_dft_analysis_bank;

    // The one command code that the package leaves without a name.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 30000;
    localparam int RANDOM_ITEMS   = 16;

    typedef struct {
        logic [pdab_pkg::CH_W-1:0] chan;
        logic signed [31:0]        re;
        logic signed [31:0]        im;
        logic                      lst;
    } bin_word_t;

    typedef struct {
        logic [1:0]         op;
        logic signed [15:0] smp;
        logic [7:0]         idx;
        logic signed [17:0] val;
        int                 reps;
        bit                 zero_bins;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] cmd = pdab_pkg::CMD_LOAD;
    logic signed [15:0] sample = '0;
    logic [7:0] coef_index = '0;
    logic signed [pdab_pkg::COEF_W-1:0] coef_value = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [pdab_pkg::CH_W-1:0] channel;
    logic signed [pdab_pkg::BIN_W-1:0] bin_real;
    logic signed [pdab_pkg::BIN_W-1:0] bin_imag;
    logic last;

    polyphase_dft_analysis_bank u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .sample(sample), .coef_index(coef_index), .coef_value(coef_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .channel(channel), .bin_real(bin_real), .bin_imag(bin_imag), .last(last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Model state: the history ring, the tap store and the twiddle tables.
    int hist_mem [pdab_pkg::NTAPS];
    int tap_mem [pdab_pkg::NTAPS];
    int fill_cnt;
    int head_slot;
    int cos_tab [pdab_pkg::CHANNELS];
    int sin_tab [pdab_pkg::CHANNELS];

    bin_word_t pending_bins [$];
    int  err_cnt = 0;
    int  idle_cycles = 0;
    bit  quiet = 1'b0;
    bit  in_busy = 1'b0;
    int  out_stall = 0;

    // Q1.15 cosine of 2*pi*j/(4*CHANNELS). The angle is kept in Q.30,
    // folded into the first quadrant, and expanded as a Taylor series.
    function automatic int cos_q15(longint unsigned j);
        longint unsigned den;
        longint unsigned th;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        longint          q;
        bit              flip;
        den  = 4 * pdab_pkg::CHANNELS;
        flip = 1'b0;
        th   = (j * 64'd6746518852 + den / 2) / den;
        if (th > 64'd6746518852) th = 64'd6746518852;
        if (th > 64'd3373259426) th = 64'd6746518852 - th;
        if (th > 64'd1686629713)
        begin
            th   = 64'd3373259426 - th;
            flip = 1'b1;
        end
        x2   = (th * th) >> 30;
        term = 64'd1 << 30;
        acc  = longint'(term);
        for (int n = 1; n <= 10; n++)
        begin
            term = ((term * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) acc -= longint'(term);
            else acc += longint'(term);
        end
        q = (acc + 16384) >>> 15;
        if (q > 32767) q = 32767;
        if (q < -32767) q = -32767;
        return flip ? int'(-q) : int'(q);
    endfunction

    function automatic longint clamp(longint v, int bits);
        longint hi;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    // Branch filter over the history ring, then the DFT of the branch sums.
    task automatic predict_block();
        longint branch [pdab_pkg::CHANNELS];
        longint acc;
        longint re;
        longint im;
        int     slot;
        bin_word_t w;
        for (int p = 0; p < pdab_pkg::CHANNELS; p++)
        begin
            acc = 0;
            for (int r = 0; r < pdab_pkg::TAPS_PER_BRANCH; r++)
            begin
                slot = (head_slot + pdab_pkg::TAPS_PER_BRANCH - r)
                     % pdab_pkg::TAPS_PER_BRANCH;
                acc += longint'(tap_mem[r * pdab_pkg::CHANNELS + p]) *
                       longint'(hist_mem[slot * pdab_pkg::CHANNELS + p]);
            end
            branch[p] = clamp((acc + 16384) >>> 15, pdab_pkg::SUM_W);
        end
        for (int k = 0; k < pdab_pkg::CHANNELS; k++)
        begin
            re = 0;
            im = 0;
            for (int p = 0; p < pdab_pkg::CHANNELS; p++)
            begin
                re += branch[p] * cos_tab[(k * p) % pdab_pkg::CHANNELS];
                im -= branch[p] * sin_tab[(k * p) % pdab_pkg::CHANNELS];
            end
            w.chan = pdab_pkg::CH_W'(k);
            w.re   = 32'(clamp((re + 16384) >>> 15, pdab_pkg::BIN_W));
            w.im   = 32'(clamp((im + 16384) >>> 15, pdab_pkg::BIN_W));
            w.lst  = (k == pdab_pkg::CHANNELS - 1);
            pending_bins.push_back(w);
        end
    endtask

    // Applies one accepted word to the model state.
    task automatic model_word(logic [1:0] op, logic signed [15:0] smp,
                              logic [7:0] idx, logic signed [17:0] val);
        if (op == pdab_pkg::CMD_LOAD)
        begin
            if (idx < pdab_pkg::NTAPS) tap_mem[idx] = val;
        end
        else if (op == pdab_pkg::CMD_RESTART)
        begin
            foreach (hist_mem[i]) hist_mem[i] = 0;
            fill_cnt  = 0;
            head_slot = 0;
        end
        else if (op == pdab_pkg::CMD_PUSH)
        begin
            hist_mem[head_slot * pdab_pkg::CHANNELS + fill_cnt] = smp;
            fill_cnt++;
            if (fill_cnt == pdab_pkg::CHANNELS)
            begin
                predict_block();
                fill_cnt  = 0;
                head_slot = (head_slot + 1) % pdab_pkg::TAPS_PER_BRANCH;
            end
        end
    endtask

    // Drives one input word after a random gap and waits for the handshake.
    // The valid line is written once per step, so a back-to-back word keeps
    // valid high without a glitch.
    task automatic send_word(logic [1:0] op, logic signed [15:0] smp,
                             logic [7:0] idx, logic signed [17:0] val);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0 && in_busy)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        else if (gap > 0)
        begin
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= op;
        sample     <= smp;
        coef_index <= idx;
        coef_value <= val;
        in_busy = 1'b1;
        @(posedge clk);
        while (!(in_valid && in_ready)) @(posedge clk);
        model_word(op, smp, idx, val);
    endtask

    task automatic drop_valid();
        if (in_busy)
        begin
            in_valid <= 1'b0;
            in_busy = 1'b0;
        end
    endtask

    // Receiver: checks each accepted result word and draws a stall per word.
    always @(posedge clk or negedge rst_n)
    begin : rx_side
        int stall_draw;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_bins.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: unexpected result word channel %0d", $time, channel);
                end
                else
                begin
                    if (channel !== pending_bins[0].chan || last !== pending_bins[0].lst ||
                        bin_real !== pending_bins[0].re || bin_imag !== pending_bins[0].im)
                    begin
                        err_cnt++;
                        $display("%0t: mismatch expected ch %0d re %0d im %0d last %0b",
                                 $time, pending_bins[0].chan, pending_bins[0].re,
                                 pending_bins[0].im, pending_bins[0].lst);
                        $display("%0t:          actual   ch %0d re %0d im %0d last %0b",
                                 $time, channel, bin_real, bin_imag, last);
                    end
                    void'(pending_bins.pop_front());
                end
                stall_draw = quiet ? 0 : $urandom_range(0, 3);
                out_ready <= (stall_draw == 0);
                out_stall <= stall_draw;
            end
            else if (out_stall > 0)
            begin
                out_ready <= (out_stall == 1);
                out_stall <= out_stall - 1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run with an error once the count of cycles in which no
    // word moves on either side reaches WATCHDOG_LIMIT.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    dir_row_t dir_rows [9];

    initial
    begin
        int sel;
        logic signed [15:0] smp;
        for (int i = 0; i < pdab_pkg::CHANNELS; i++)
        begin
            cos_tab[i] = cos_q15(4 * i);
            sin_tab[i] = cos_q15((4 * i + 3 * pdab_pkg::CHANNELS)
                                 % (4 * pdab_pkg::CHANNELS));
        end
        foreach (hist_mem[i]) hist_mem[i] = 0;
        foreach (tap_mem[i]) tap_mem[i] = 0;
        fill_cnt  = 0;
        head_slot = 0;

        // The tap index is eight bits wide and the store holds exactly 256
        // taps, so no index can fall out of range here.
        dir_rows = '{
            '{pdab_pkg::CMD_LOAD,    16'sd0,      8'd0,   18'sd131071,  1, 1'b0},
            '{pdab_pkg::CMD_LOAD,    16'sd0,      8'd255, -18'sd131072, 1, 1'b0},
            '{pdab_pkg::CMD_LOAD,    16'sd0,      8'd85,  18'sd0,       1, 1'b0},
            '{CMD_UNUSED,            -16'sd1,     8'd255, -18'sd1,      1, 1'b0},
            '{pdab_pkg::CMD_PUSH,    16'sd0,      8'd0,   18'sd0,      64, 1'b1},
            '{pdab_pkg::CMD_PUSH,    16'sd1,      8'd0,   18'sd0,       6, 1'b0},
            '{pdab_pkg::CMD_RESTART, 16'sd0,      8'd0,   18'sd0,       1, 1'b0},
            '{pdab_pkg::CMD_PUSH,    16'sd32767,  8'd0,   18'sd0,      32, 1'b0},
            '{pdab_pkg::CMD_PUSH,    -16'sd32768, 8'd0,   18'sd0,      32, 1'b0}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every tap must hold a value before the first block completes.
        for (int i = 0; i < pdab_pkg::NTAPS; i++)
            send_word(pdab_pkg::CMD_LOAD, 16'sd0, 8'(i), 18'($urandom));

        // Directed table. A zero block, fed into a cleared history, has all
        // bins at zero, so that row carries a typed-in expectation.
        foreach (dir_rows[r])
        begin
            for (int n = 0; n < dir_rows[r].reps; n++)
            begin
                send_word(dir_rows[r].op, dir_rows[r].smp, dir_rows[r].idx, dir_rows[r].val);
                if (dir_rows[r].zero_bins && pending_bins.size() == pdab_pkg::CHANNELS)
                begin
                    foreach (pending_bins[i])
                    begin
                        pending_bins[i].re = 32'sd0;
                        pending_bins[i].im = 32'sd0;
                    end
                end
            end
        end

        // The sender holds off until the receiver has drained every result.
        drop_valid();
        do @(posedge clk); while (pending_bins.size() != 0);

        // Random part: mostly sample pushes, mixed with tap reloads, restarts
        // and unused commands. The partial block it leaves is held.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 8 == 4) quiet = ~quiet;
            sel = $urandom_range(0, 99);
            case ($urandom_range(0, 9))
                0: smp = 16'sd32767;
                1: smp = -16'sd32768;
                default: smp = 16'($urandom);
            endcase
            if (sel < 86)
                send_word(pdab_pkg::CMD_PUSH, smp, 8'($urandom), 18'($urandom));
            else if (sel < 94)
                send_word(pdab_pkg::CMD_LOAD, 16'($urandom), 8'($urandom), 18'($urandom));
            else if (sel < 97)
                send_word(pdab_pkg::CMD_RESTART, smp, 8'($urandom), 18'($urandom));
            else
                send_word(CMD_UNUSED, smp, 8'($urandom), 18'($urandom));
        end
        drop_valid();
        quiet = 1'b0;

        while (pending_bins.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);

        if (err_cnt == 0 && pending_bins.size() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
